[rtl/fas_pkg.sv]
// frame animation sequencer: shared types and constants
// used by fas_cfg_regs, fas_step and frame_animation_sequencer

package fas_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int TIME_BITS  = 32;
    localparam int FRAME_BITS = 8;
    localparam int COUNT_BITS = 9;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    // opcode of an input item
    typedef enum logic [0:0] {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    // register word indexes (byte address is 4 times this)
    localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
    localparam logic [2:0] REG_FRAMES_USED  = 3'd1;
    localparam logic [2:0] REG_SHEET_FRAMES = 3'd2;
    localparam logic [2:0] REG_HOLD_FRAME   = 3'd3;
    localparam logic [2:0] REG_HOLD_TIME    = 3'd4;
    localparam logic [2:0] REG_LOOP_LIMIT   = 3'd5;

    localparam logic [9:0]            PERIOD_RESET = 10'd100;
    localparam logic signed [16:0]    LOOP_FOREVER = -17'sd1;
    localparam logic [COUNT_BITS-1:0] USED_MAX     = COUNT_BITS'(MAX_FRAMES);
    localparam logic [15:0]           PASSES_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [9:0]            frame_period_ms;
        logic [COUNT_BITS-1:0] frames_used;
        logic [COUNT_BITS-1:0] sheet_frames;
        logic signed [8:0]     hold_frame;
        logic [31:0]           hold_time_ms;
        logic signed [16:0]    loop_limit;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame_now;
        logic [TIME_BITS-1:0]  last_advance_ms;
        logic                  done_flag;
        logic [15:0]           passes_done;
        logic                  holding;
        logic [TIME_BITS-1:0]  hold_start_ms;
    } seq_state_t;

endpackage

[rtl/fas_cfg_regs.sv]
// frame animation sequencer: APB-style configuration registers
// depends on fas_pkg

module fas_cfg_regs
    import fas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] word_idx;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign word_idx = paddr[ADDR_BITS-1:2];
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_period_ms <= PERIOD_RESET;
            cfg_reg.frames_used     <= '0;
            cfg_reg.sheet_frames    <= '0;
            cfg_reg.hold_frame      <= -9'sd1;
            cfg_reg.hold_time_ms    <= '0;
            cfg_reg.loop_limit      <= LOOP_FOREVER;
        end
        else if (wr_en)
        begin
            unique case (word_idx)
                REG_FRAME_PERIOD: cfg_reg.frame_period_ms <= pwdata[9:0];
                REG_FRAMES_USED:  cfg_reg.frames_used     <= pwdata[COUNT_BITS-1:0];
                REG_SHEET_FRAMES: cfg_reg.sheet_frames    <= pwdata[COUNT_BITS-1:0];
                REG_HOLD_FRAME:   cfg_reg.hold_frame      <= pwdata[8:0];
                REG_HOLD_TIME:    cfg_reg.hold_time_ms    <= pwdata[31:0];
                REG_LOOP_LIMIT:   cfg_reg.loop_limit      <= pwdata[16:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (word_idx)
            REG_FRAME_PERIOD: prdata = DATA_BITS'(cfg_reg.frame_period_ms);
            REG_FRAMES_USED:  prdata = DATA_BITS'(cfg_reg.frames_used);
            REG_SHEET_FRAMES: prdata = DATA_BITS'(cfg_reg.sheet_frames);
            REG_HOLD_FRAME:   prdata = DATA_BITS'(cfg_reg.hold_frame);
            REG_HOLD_TIME:    prdata = DATA_BITS'(cfg_reg.hold_time_ms);
            REG_LOOP_LIMIT:   prdata = DATA_BITS'(cfg_reg.loop_limit);
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/fas_step.sv]
// frame animation sequencer: next-state and result logic for one item
// depends on fas_pkg

module fas_step
    import fas_pkg::*;
(
    input  cfg_t                  cfg,
    input  seq_state_t            state,
    input  opcode_t               opcode,
    input  logic [TIME_BITS-1:0]  now_ms,
    output seq_state_t            state_next,
    output logic                  draw,
    output logic [FRAME_BITS-1:0] frame_index,
    output logic                  finished
);

    logic [COUNT_BITS-1:0] used_eff;
    logic [TIME_BITS-1:0]  since_advance;
    logic [TIME_BITS-1:0]  since_hold;
    logic [COUNT_BITS-1:0] frame_inc;
    logic [COUNT_BITS-1:0] used_last;
    logic [15:0]           passes_inc;
    logic                  active;
    logic                  due;
    logic                  at_hold;
    logic                  advance;

    always_comb
    begin
        used_eff = (cfg.frames_used < cfg.sheet_frames) ? cfg.frames_used : cfg.sheet_frames;
        if (used_eff > USED_MAX)
        begin
            used_eff = USED_MAX;
        end
        used_last     = used_eff - COUNT_BITS'(1);
        since_advance = now_ms - state.last_advance_ms;
        since_hold    = now_ms - state.hold_start_ms;
        due           = since_advance >= TIME_BITS'(cfg.frame_period_ms);
        at_hold       = !cfg.hold_frame[8] && (state.frame_now == cfg.hold_frame[7:0]);
        frame_inc     = COUNT_BITS'(state.frame_now) + COUNT_BITS'(1);
        passes_inc    = (state.passes_done == PASSES_MAX) ? state.passes_done
                                                          : state.passes_done + 16'd1;
        active        = (cfg.frames_used != '0) && (cfg.sheet_frames != '0) && !state.done_flag;
        advance       = 1'b0;
        state_next    = state;
        draw          = 1'b0;

        if (opcode == OP_RESTART)
        begin
            state_next                 = '0;
            state_next.last_advance_ms = now_ms;
        end
        else if (active)
        begin
            if (due)
            begin
                advance = 1'b1;
                if (at_hold)
                begin
                    priority if (!state.holding)
                    begin
                        state_next.holding       = 1'b1;
                        state_next.hold_start_ms = now_ms;
                        advance                  = 1'b0;
                    end
                    else if (since_hold >= cfg.hold_time_ms)
                    begin
                        state_next.holding = 1'b0;
                    end
                    else
                    begin
                        advance = 1'b0;
                    end
                end
            end

            if (advance)
            begin
                state_next.last_advance_ms = now_ms;
                if (frame_inc >= used_eff)
                begin
                    if (cfg.loop_limit == LOOP_FOREVER)
                    begin
                        state_next.frame_now = '0;
                    end
                    else
                    begin
                        state_next.passes_done = passes_inc;
                        // a negative limit finishes on the first wrap
                        if ($signed({1'b0, passes_inc}) >= cfg.loop_limit)
                        begin
                            state_next.done_flag = 1'b1;
                            state_next.frame_now = used_last[FRAME_BITS-1:0];
                        end
                        else
                        begin
                            state_next.frame_now = '0;
                        end
                    end
                end
                else
                begin
                    state_next.frame_now = frame_inc[FRAME_BITS-1:0];
                end
            end

            draw = !state_next.done_flag
                && (COUNT_BITS'(state_next.frame_now) < cfg.sheet_frames);
        end

        frame_index = state_next.frame_now;
        finished    = state_next.done_flag;
    end

endmodule

[rtl/frame_animation_sequencer.sv]
// frame animation sequencer top level: item pipeline and sequence state
// depends on fas_pkg, fas_cfg_regs, fas_step
//
// usage:
// - item channel (item_valid/item_ready) carries opcode and now_ms; a tick
//   advances the frame once frame_period_ms has passed, a restart clears
//   the sequence and takes now_ms as the new time base
// - result channel (result_valid/result_ready) returns draw, frame_index and
//   finished, exactly one result per item, in order
// - the item is registered in the input register at the accept edge, and its
//   result is registered in the result register when it moves on; the sequence
//   state updates on that same edge
// - throughput: one item per cycle, limited only by the result side
// - stalls: an input register and a result register hold one item each, so
//   the block keeps accepting while a result waits; item_ready drops only
//   when both are full and result_ready is low
// - configuration goes through the APB-style port (always ready); the user
//   must write it only while no item is in flight, not enforced by the block
// - reset: registers take their reset values (period 100, hold and loop
//   limit disabled), sequence at frame 0, both stages empty

module frame_animation_sequencer
    import fas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  opcode,
    input  logic [TIME_BITS-1:0]  now_ms,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  draw,
    output logic [FRAME_BITS-1:0] frame_index,
    output logic                  finished
);

    cfg_t                  cfg;
    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic                  s1_valid_reg;
    opcode_t               s1_opcode_reg;
    logic [TIME_BITS-1:0]  s1_now_reg;
    logic                  out_valid_reg;
    logic                  draw_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic                  finished_reg;
    logic                  draw_next;
    logic [FRAME_BITS-1:0] frame_next;
    logic                  finished_next;
    logic                  s1_move;
    logic                  item_take;

    fas_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fas_step u_step (
        .cfg         (cfg),
        .state       (state_reg),
        .opcode      (s1_opcode_reg),
        .now_ms      (s1_now_reg),
        .state_next  (state_next),
        .draw        (draw_next),
        .frame_index (frame_next),
        .finished    (finished_next)
    );

    assign s1_move      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || s1_move;
    assign item_take    = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign draw         = draw_reg;
    assign frame_index  = frame_reg;
    assign finished     = finished_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (item_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_opcode_reg <= opcode_t'(opcode);
            s1_now_reg    <= now_ms;
        end
        if (s1_move)
        begin
            draw_reg     <= draw_next;
            frame_reg    <= frame_next;
            finished_reg <= finished_next;
        end
    end

    a_finished_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && finished_reg |-> !draw_reg)
        else $error("finished result reports a drawn frame");

    a_done_frame_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.done_flag && !(s1_move && s1_opcode_reg == OP_RESTART)
        |=> $stable(state_reg.frame_now) && state_reg.done_flag)
        else $error("finished sequence moved without restart");

    a_passes_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_move && s1_opcode_reg == OP_RESTART)
        |=> state_reg.passes_done >= $past(state_reg.passes_done))
        else $error("pass counter went backwards");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_now_reg))
        else $error("stalled item lost from input register");

endmodule
